@@ sv/selectable_murmur3_fnv1a_hash_core_macros.svh @@
// Assertion macros shared by the hash core checker.
`ifndef SELECTABLE_MURMUR3_FNV1A_HASH_CORE_MACROS_SVH
`define SELECTABLE_MURMUR3_FNV1A_HASH_CORE_MACROS_SVH

// Property checked at every clock edge outside reset.
`define SMFH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that must also hold while reset is asserted.
`define SMFH_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/smfh_pkg.sv @@
// Types, constants and helper functions of the selectable Murmur3 / FNV-1a hash core.
`default_nettype none
package smfh_pkg;

  localparam int unsigned HASH_W     = 32;
  localparam int unsigned PEND_W     = 24;
  localparam int unsigned CFG_IDX_W  = 1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ALGORITHM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_SEED = 1'b1;

  // Algorithm codes
  localparam logic ALG_MURMUR = 1'b0;
  localparam logic ALG_FNV    = 1'b1;

  localparam logic [HASH_W-1:0] MM_C1     = 32'hcc9e2d51;
  localparam logic [HASH_W-1:0] MM_C2     = 32'h1b873593;
  localparam logic [HASH_W-1:0] MM_N      = 32'he6546b64;
  localparam logic [HASH_W-1:0] MM_F1     = 32'h85ebca6b;
  localparam logic [HASH_W-1:0] MM_F2     = 32'hc2b2ae35;
  localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811c9dc5;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'h01000193;

  typedef struct packed {
    logic              algorithm;
    logic [HASH_W-1:0] hash_seed;
  } cfg_t;

  function automatic logic [HASH_W-1:0] rotl32(input logic [HASH_W-1:0] x,
                                                input int unsigned r);
    return (x << r) | (x >> (HASH_W - r));
  endfunction

endpackage
`default_nettype wire

@@ sv/selectable_murmur3_fnv1a_hash_core.sv @@
// Top level of the selectable Murmur3 / FNV-1a hash core: ports, registers, output stage.
`default_nettype none
// Hashes a byte stream, at most one byte per input beat, and returns the 32-bit hash
// on the beat marked tlast. algorithm 0 selects MurmurHash3 x86_32 seeded by hash_seed,
// 1 selects FNV-1a 32. A register write discards any message in progress. One
// 32x32 multiplier with a registered product serves every multiply, so the states
// a beat passes through follow its use: a beat with no byte and no tlast leaves
// ST_IDLE unchanged; FNV-1a takes each byte through ST_FNV; Murmur keeps a byte that
// leaves its 4-byte block open in ST_IDLE and takes the byte that completes it through
// ST_BK1 and ST_BK2. On tlast the Murmur finalizer runs ST_MIX0 to ST_MIX2 (ST_TL1
// to ST_TL3, ST_MIX1, ST_MIX2 with 1 to 3 tail bytes); the result goes via ST_OUT to
// the output register to wait for out_tready while the next message is taken in.
module selectable_murmur3_fnv1a_hash_core #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [7:0]                          in_tdata,   // [7:0] data_byte
  input  wire logic                                in_tuser,   // [0] byte_present
  input  wire logic                                in_tlast,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [smfh_pkg::HASH_W-1:0]         out_tdata,  // [31:0] hash_value
  input  wire logic                                cfg_we,
  input  wire logic [smfh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [smfh_pkg::HASH_W-1:0]         cfg_wdata
);

  smfh_pkg::cfg_t               cfg_r, cfg_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [smfh_pkg::HASH_W-1:0]  out_data_r, out_data_nxt;
  logic                         res_valid;
  logic                         res_ready;
  logic [smfh_pkg::HASH_W-1:0]  res_hash;

  smfh_seq #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .cfg_clear    (cfg_we),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .data_byte    (in_tdata),
    .byte_present (in_tuser),
    .last         (in_tlast),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_hash     (res_hash)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        smfh_pkg::REG_ALGORITHM: cfg_nxt.algorithm = cfg_wdata[0];
        smfh_pkg::REG_HASH_SEED: cfg_nxt.hash_seed = cfg_wdata;
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_hash;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

@@ sv/smfh_mul.sv @@
// Shared 32x32 multiplier keeping the low 32 product bits in a register.
`default_nettype none
module smfh_mul (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [smfh_pkg::HASH_W-1:0]   a,
  input  wire logic [smfh_pkg::HASH_W-1:0]   b,
  output logic      [smfh_pkg::HASH_W-1:0]   p_r
);

  logic [2*smfh_pkg::HASH_W-1:0] full;
  logic [smfh_pkg::HASH_W-1:0]   p_nxt;

  assign full  = a * b;
  assign p_nxt = en ? full[smfh_pkg::HASH_W-1:0] : p_r;

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule
`default_nettype wire

@@ sv/smfh_seq.sv @@
// Sequencer and message state: drives the shared multiplier through the hash steps.
`default_nettype none
module smfh_seq #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire smfh_pkg::cfg_t                cfg,
  input  wire logic                          cfg_clear,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    data_byte,
  input  wire logic                          byte_present,
  input  wire logic                          last,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output logic      [smfh_pkg::HASH_W-1:0]   res_hash
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_FNV  = 4'd1;
  localparam logic [3:0] ST_BK1  = 4'd2;
  localparam logic [3:0] ST_BK2  = 4'd3;
  localparam logic [3:0] ST_TL1  = 4'd4;
  localparam logic [3:0] ST_TL2  = 4'd5;
  localparam logic [3:0] ST_TL3  = 4'd6;
  localparam logic [3:0] ST_MIX0 = 4'd7;
  localparam logic [3:0] ST_MIX1 = 4'd8;
  localparam logic [3:0] ST_MIX2 = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;

  localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

  logic [3:0]                    state_r, state_nxt;
  logic                          in_msg_r, in_msg_nxt;
  logic [smfh_pkg::HASH_W-1:0]   hash_r, hash_nxt;
  logic [smfh_pkg::PEND_W-1:0]   pend_r, pend_nxt;
  logic [1:0]                    cnt_r, cnt_nxt;
  logic [LENGTH_BITS-1:0]        len_r, len_nxt;
  logic                          last_r, last_nxt;
  logic [smfh_pkg::HASH_W-1:0]   res_r, res_nxt;

  logic [smfh_pkg::HASH_W-1:0]   hash_eff;
  logic [smfh_pkg::PEND_W-1:0]   pend_eff;
  logic [1:0]                    cnt_eff;
  logic [LENGTH_BITS-1:0]        len_eff;
  logic [smfh_pkg::HASH_W-1:0]   block;
  logic [smfh_pkg::HASH_W-1:0]   rot_t;
  logic [smfh_pkg::HASH_W-1:0]   mix_x;
  logic [smfh_pkg::HASH_W-1:0]   mix_src;
  logic                          accept;

  logic                          mul_en;
  logic [smfh_pkg::HASH_W-1:0]   mul_a;
  logic [smfh_pkg::HASH_W-1:0]   mul_b;
  logic [smfh_pkg::HASH_W-1:0]   mul_p;

  smfh_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready && (byte_present || last);
  assign res_valid = (state_r == ST_OUT);
  assign res_hash  = res_r;

  // A new message starts from the seed or the offset basis
  assign hash_eff = in_msg_r ? hash_r :
                    ((cfg.algorithm == smfh_pkg::ALG_FNV) ? smfh_pkg::FNV_BASIS
                                                          : cfg.hash_seed);
  assign pend_eff = in_msg_r ? pend_r : '0;
  assign cnt_eff  = in_msg_r ? cnt_r : 2'd0;
  assign len_eff  = in_msg_r ? len_r : '0;
  assign block    = {data_byte, pend_eff};

  assign rot_t   = smfh_pkg::rotl32(hash_r ^ mul_p, 13);
  assign mix_src = ((state_r == ST_TL3) ? (hash_r ^ mul_p) : hash_r) ^ 32'(len_r);
  assign mix_x   = mix_src ^ (mix_src >> 16);

  always_comb begin
    state_nxt  = state_r;
    in_msg_nxt = in_msg_r;
    hash_nxt   = hash_r;
    pend_nxt   = pend_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    last_nxt   = last_r;
    res_nxt    = res_r;
    mul_en     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          in_msg_nxt = 1'b1;
          hash_nxt   = hash_eff;
          pend_nxt   = pend_eff;
          cnt_nxt    = cnt_eff;
          len_nxt    = byte_present ? (len_eff + LEN_ONE) : len_eff;
          last_nxt   = last;
          if (cfg.algorithm == smfh_pkg::ALG_FNV) begin
            if (byte_present) begin
              mul_en    = 1'b1;
              mul_a     = hash_eff ^ {24'h0, data_byte};
              mul_b     = smfh_pkg::FNV_PRIME;
              state_nxt = ST_FNV;
            end else begin
              res_nxt   = hash_eff;
              state_nxt = ST_OUT;
            end
          end else if (byte_present && (cnt_eff == 2'd3)) begin
            mul_en    = 1'b1;
            mul_a     = block;
            mul_b     = smfh_pkg::MM_C1;
            pend_nxt  = '0;
            cnt_nxt   = 2'd0;
            state_nxt = ST_BK1;
          end else if (byte_present) begin
            pend_nxt = pend_eff | (smfh_pkg::PEND_W'(data_byte) << {cnt_eff, 3'b000});
            cnt_nxt  = cnt_eff + 2'd1;
            if (last) begin
              state_nxt = ST_TL1;
            end
          end else begin
            state_nxt = (cnt_eff != 2'd0) ? ST_TL1 : ST_MIX0;
          end
        end
      end
      ST_FNV: begin
        hash_nxt = mul_p;
        if (last_r) begin
          res_nxt   = mul_p;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_BK1: begin
        mul_en    = 1'b1;
        mul_a     = smfh_pkg::rotl32(mul_p, 15);
        mul_b     = smfh_pkg::MM_C2;
        state_nxt = ST_BK2;
      end
      ST_BK2: begin
        // h = rotl(h ^ k, 13) * 5 + n
        hash_nxt  = (rot_t << 2) + rot_t + smfh_pkg::MM_N;
        state_nxt = last_r ? ST_MIX0 : ST_IDLE;
      end
      ST_TL1: begin
        mul_en    = 1'b1;
        mul_a     = {8'h00, pend_r};
        mul_b     = smfh_pkg::MM_C1;
        state_nxt = ST_TL2;
      end
      ST_TL2: begin
        mul_en    = 1'b1;
        mul_a     = smfh_pkg::rotl32(mul_p, 15);
        mul_b     = smfh_pkg::MM_C2;
        state_nxt = ST_TL3;
      end
      ST_TL3, ST_MIX0: begin
        mul_en    = 1'b1;
        mul_a     = mix_x;
        mul_b     = smfh_pkg::MM_F1;
        state_nxt = ST_MIX1;
      end
      ST_MIX1: begin
        mul_en    = 1'b1;
        mul_a     = mul_p ^ (mul_p >> 13);
        mul_b     = smfh_pkg::MM_F2;
        state_nxt = ST_MIX2;
      end
      ST_MIX2: begin
        res_nxt   = mul_p ^ (mul_p >> 16);
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (res_ready) begin
          in_msg_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Drop the message in progress on any register write
    if (cfg_clear) begin
      in_msg_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      in_msg_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      in_msg_r <= in_msg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hash_r <= hash_nxt;
    pend_r <= pend_nxt;
    cnt_r  <= cnt_nxt;
    len_r  <= len_nxt;
    last_r <= last_nxt;
    res_r  <= res_nxt;
  end

endmodule
`default_nettype wire

@@ sv/smfh_chk.sv @@
// Port-level checker for the hash core, bound to the top level.
`default_nettype none
`include "selectable_murmur3_fnv1a_hash_core_macros.svh"
module smfh_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tvalid,
  input wire logic                        in_tready,
  input wire logic                        in_tuser,
  input wire logic                        in_tlast,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [smfh_pkg::HASH_W-1:0] out_tdata
);

  `SMFH_ASSERT_RST(a_rst_empty, clk, !rst_n |=> !out_tvalid, "result beat right after reset")
  `SMFH_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "result beat dropped")
  `SMFH_ASSERT(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata), "stalled hash changed")
  `SMFH_ASSERT(a_last_busy, clk, rst_n, in_tvalid && in_tready && in_tlast |=> !in_tready, "input ready right after a last beat")
  `SMFH_ASSERT(a_idle_beat, clk, rst_n, in_tvalid && in_tready && !in_tuser && !in_tlast |=> in_tready, "empty beat stalled the input")

endmodule

bind selectable_murmur3_fnv1a_hash_core smfh_chk u_smfh_chk (.*);
`default_nettype wire
